/* rtl/imh_pkg.sv */
`timescale 1ns / 1ps
package imh_pkg;
    localparam int HEAP_DEPTH = 1024;
    localparam int ID_SPACE   = 1024;
    localparam int PW = $clog2(HEAP_DEPTH + 1);   // position / count width
    localparam int AW = $clog2(HEAP_DEPTH);       // heap memory address width
    localparam int IW = $clog2(ID_SPACE);
    localparam int KW = 31;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_PRESENT  = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_LOOK,      // position table read returns
        S_INS,
        S_TAKE_RD,   // last entry returns, fetch the hole entry
        S_TAKE_WR,
        S_DN_RD,     // fetch left child
        S_DN_LR,     // left child returns, fetch right child
        S_DN_DEC,
        S_DN_END,
        S_UP_DEC,
        S_UP_WB,
        S_ROOT_RD,
        S_ROOT_WT,
        S_OUT
    } t_state;
endpackage

/* rtl/imh_if.sv */
`timescale 1ns / 1ps
interface imh_in_if;
    import imh_pkg::*;
    logic          valid;
    logic          ready;
    logic [1:0]    cmd;
    logic [IW-1:0] timer_id;
    logic [KW-1:0] expire_time;
    modport source (output valid, cmd, timer_id, expire_time, input ready);
    modport sink   (input valid, cmd, timer_id, expire_time, output ready);
endinterface

interface imh_out_if;
    import imh_pkg::*;
    logic          valid;
    logic          ready;
    logic [2:0]    status;
    logic [IW-1:0] item_id;
    logic [KW-1:0] item_expire;
    logic [PW-1:0] heap_count;
    modport source (output valid, status, item_id, item_expire, heap_count, input ready);
    modport sink   (input valid, status, item_id, item_expire, heap_count, output ready);
endinterface

/* rtl/indexed_min_heap_timer_queue.sv */
`timescale 1ns / 1ps
// One item in flight: a command is taken in S_IDLE and worked through the states; a sift
// runs level by level, up the heap or down it, and sets how long an item is held.
// The result waits in S_OUT while the output register is full and not draining; the next item
// is taken in the cycle after the result enters the output register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all ID_SPACE (1024) entries
// of the position table, during which no item is accepted.
module indexed_min_heap_timer_queue
    import imh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    imh_in_if.sink   i_in,
    imh_out_if.source o_out
);
    // heap memory: one entry is {id, key}, position 1 stored at address 0
    logic [IW+KW-1:0] r_heap [HEAP_DEPTH];
    logic [PW-1:0]    r_pos  [ID_SPACE];

    logic             heap_we;
    logic [AW-1:0]    heap_wa, heap_ra;
    logic [IW+KW-1:0] heap_wd, r_heap_rd;
    logic             pos_we;
    logic [IW-1:0]    pos_wa, pos_ra;
    logic [PW-1:0]    pos_wd, r_pos_rd;

    always_ff @(posedge i_clk) begin
        if (heap_we) r_heap[heap_wa] <= heap_wd;
        r_heap_rd <= r_heap[heap_ra];
    end
    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos[pos_wa] <= pos_wd;
        r_pos_rd <= r_pos[pos_ra];
    end

    t_state r_state, n_state;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_p, n_p;        // node being sifted
    logic [PW-1:0] r_start, n_start;
    logic [IW+KW-1:0] r_node, n_node, r_left, n_left;
    t_cmd          r_cmd, n_cmd;
    logic [IW-1:0] r_id, n_id;
    logic [KW-1:0] r_key, n_key;
    logic          r_mayrise, n_mayrise;
    t_status       r_status, n_status;
    logic          r_popped, n_popped;
    logic [IW+KW-1:0] r_res, n_res;
    logic          r_ov, n_ov;
    logic [IW-1:0] r_clr, n_clr;

    // output register: holds one result while the next item is worked
    t_status          r_o_status;
    logic [IW+KW-1:0] r_o_res;
    logic [PW-1:0]    r_o_cnt;
    logic             out_load;

    logic [PW:0]      l_pos, rt_pos;
    logic [PW-1:0]    m_pos, up_pos;
    logic             use_r;
    logic [IW+KW-1:0] m_ent;

    function automatic logic [AW-1:0] adr(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = p - PW'(1);
        return q[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_clr   <= n_clr;
        end
    end
    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_start <= n_start; r_node <= n_node; r_left <= n_left;
        r_cmd <= n_cmd; r_id <= n_id; r_key <= n_key; r_mayrise <= n_mayrise;
        r_status <= n_status; r_popped <= n_popped; r_res <= n_res;
    end
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_res    <= r_res;
            r_o_cnt    <= r_cnt;
        end
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_p = r_p; n_start = r_start;
        n_node = r_node; n_left = r_left;
        n_cmd = r_cmd; n_id = r_id; n_key = r_key; n_mayrise = r_mayrise;
        n_status = r_status; n_popped = r_popped; n_res = r_res; n_ov = r_ov;
        n_clr = r_clr;
        out_load = 1'b0;
        heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
        pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_ra = '0;
        i_in.ready = 1'b0;
        // children of the node; one bit wider so a deep node cannot wrap
        l_pos   = {r_p, 1'b0};
        rt_pos  = {r_p, 1'b1};
        // right child wins when present and the left one is not strictly earlier
        use_r   = (rt_pos <= {1'b0, r_cnt}) && !(r_left[KW-1:0] < r_heap_rd[KW-1:0]);
        m_pos   = use_r ? rt_pos[PW-1:0] : l_pos[PW-1:0];
        m_ent   = use_r ? r_heap_rd : r_left;
        up_pos  = r_p >> 1;

        if (o_out.ready) n_ov = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                pos_we = 1'b1; pos_wa = r_clr; pos_wd = '0;
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(ID_SPACE - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                pos_ra = i_in.timer_id;
                if (i_in.valid) begin
                    n_cmd = t_cmd'(i_in.cmd); n_id = i_in.timer_id;
                    n_key = i_in.expire_time;
                    n_status = ST_OK; n_popped = 1'b0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        // fullness is checked before duplication
                        if (r_cnt >= PW'(HEAP_DEPTH)) begin
                            n_status = ST_FULL; n_state = S_ROOT_RD;
                        end else if (r_pos_rd != '0) begin
                            n_status = ST_PRESENT; n_state = S_ROOT_RD;
                        end else begin
                            n_cnt = r_cnt + PW'(1);
                            n_p = r_cnt + PW'(1);
                            n_state = S_INS;
                        end
                    end
                    CMD_POP: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY; n_state = S_ROOT_RD;
                        end else begin
                            n_popped = 1'b1; n_p = PW'(1); n_mayrise = 1'b0;
                            heap_ra = adr(r_cnt); n_state = S_TAKE_RD;
                        end
                    end
                    CMD_DELETE: begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY; n_state = S_ROOT_RD;
                        end else if (r_pos_rd == '0 || r_pos_rd > r_cnt) begin
                            n_status = ST_NOTFOUND; n_state = S_ROOT_RD;
                        end else begin
                            n_p = r_pos_rd; n_mayrise = 1'b1;
                            heap_ra = adr(r_cnt); n_state = S_TAKE_RD;
                        end
                    end
                    default: n_state = S_ROOT_RD;
                endcase
            end
            S_INS: begin
                // place the new entry at the end, then sift up
                heap_we = 1'b1; heap_wa = adr(r_p); heap_wd = {r_id, r_key};
                pos_we = 1'b1; pos_wa = r_id; pos_wd = r_p;
                n_node = {r_id, r_key};
                heap_ra = adr(up_pos);
                n_state = (r_p == PW'(1)) ? S_ROOT_RD : S_UP_DEC;
            end
            S_TAKE_RD: begin
                // read data holds the last entry; fetch the hole entry
                n_node = r_heap_rd;
                heap_ra = adr(r_p);
                n_state = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                // drop the hole entry; the last entry lands in the hole when the sift ends
                if (r_popped) n_res = r_heap_rd;
                pos_we = 1'b1; pos_wa = r_heap_rd[IW+KW-1:KW]; pos_wd = '0;
                n_cnt = r_cnt - PW'(1);
                if (r_p != r_cnt) begin
                    n_start = r_p;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_ROOT_RD;
                end
            end
            S_DN_RD: begin
                if (l_pos > {1'b0, r_cnt}) begin
                    n_state = S_DN_END;
                end else begin
                    heap_ra = adr(l_pos[PW-1:0]); n_state = S_DN_LR;
                end
            end
            S_DN_LR: begin
                n_left = r_heap_rd;
                heap_ra = adr(rt_pos[PW-1:0]);
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                // right child in read data; hold the node, move the chosen child up
                if (r_node[KW-1:0] < m_ent[KW-1:0]) begin
                    n_state = S_DN_END;
                end else begin
                    heap_we = 1'b1; heap_wa = adr(r_p); heap_wd = m_ent;
                    pos_we = 1'b1; pos_wa = m_ent[IW+KW-1:KW]; pos_wd = r_p;
                    n_p = m_pos;
                    n_state = S_DN_RD;
                end
            end
            S_DN_END: begin
                // settle the node; a delete whose node did not sink may still rise
                heap_we = 1'b1; heap_wa = adr(r_p); heap_wd = r_node;
                pos_we = 1'b1; pos_wa = r_node[IW+KW-1:KW]; pos_wd = r_p;
                if (r_p == r_start && r_mayrise && r_p != PW'(1)) begin
                    heap_ra = adr(up_pos); n_state = S_UP_DEC;
                end else begin
                    n_state = S_ROOT_RD;
                end
            end
            S_UP_DEC: begin
                // parent entry in read data; equal keys move up
                if (r_heap_rd[KW-1:0] < r_node[KW-1:0]) begin
                    n_state = S_ROOT_RD;
                end else begin
                    heap_we = 1'b1; heap_wa = adr(r_p); heap_wd = r_heap_rd;
                    pos_we = 1'b1; pos_wa = r_heap_rd[IW+KW-1:KW]; pos_wd = r_p;
                    n_p = up_pos;
                    n_state = S_UP_WB;
                end
            end
            S_UP_WB: begin
                heap_we = 1'b1; heap_wa = adr(r_p); heap_wd = r_node;
                pos_we = 1'b1; pos_wa = r_node[IW+KW-1:KW]; pos_wd = r_p;
                heap_ra = adr(up_pos);
                n_state = (r_p == PW'(1)) ? S_ROOT_RD : S_UP_DEC;
            end
            S_ROOT_RD: begin
                heap_ra = '0;
                n_state = S_ROOT_WT;
            end
            S_ROOT_WT: begin
                if (!r_popped) n_res = (r_cnt == '0) ? '0 : r_heap_rd;
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait until the output register is free or drains this cycle
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out.valid       = r_ov;
    assign o_out.status      = r_o_status;
    assign o_out.item_id     = r_o_res[IW+KW-1:KW];
    assign o_out.item_expire = r_o_res[KW-1:0];
    assign o_out.heap_count  = r_o_cnt;
endmodule

/* tb/sv/indexed_min_heap_timer_queue_tb.sv */
`timescale 1ns / 1ps
module indexed_min_heap_timer_queue_tb;
    import imh_pkg::*;

    // Idle cycles with no item accepted on either side before the run is given up.
    // This covers the clearing pass after reset, the long receiver hold and the
    // deepest sift under heavy stalls.
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_MODE = 230;

    typedef struct packed {
        logic [2:0]    status;
        logic [IW-1:0] id;
        logic [KW-1:0] expire;
        logic [PW-1:0] count;
    } t_result;

    typedef struct {
        t_cmd          cmd;
        logic [IW-1:0] id;
        logic [KW-1:0] key;
        bit            typed;
        t_result       res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    imh_in_if  in_if ();
    imh_out_if out_if ();

    indexed_min_heap_timer_queue u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // Shadow timer queue: heap entries, id position table and entry count.
    logic [IW-1:0] sh_ids  [1:HEAP_DEPTH];
    logic [KW-1:0] sh_keys [1:HEAP_DEPTH];
    logic [PW-1:0] sh_pos  [0:ID_SPACE-1];
    int            sh_count;

    t_result results_due[$];
    int      tx_idle_pct;
    int      rx_idle_pct;
    bit      rx_hold_req;
    int      n_sent;
    int      n_checked;
    int      n_errors;
    int      stall_cycles;
    int      status_seen[5];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction
    function automatic void heap_swap(int a, int b);
        logic [IW-1:0] tid;
        logic [KW-1:0] tkey;
        tid = sh_ids[a];
        tkey = sh_keys[a];
        sh_ids[a] = sh_ids[b];
        sh_keys[a] = sh_keys[b];
        sh_ids[b] = tid;
        sh_keys[b] = tkey;
        sh_pos[sh_ids[a]] = PW'(a);
        sh_pos[sh_ids[b]] = PW'(b);
    endfunction

    // Move up while the parent is not strictly earlier, so equal keys rise.
    function automatic void heap_rise(int p);
        int up;
        while (p > 1) begin
            up = p / 2;
            if (sh_keys[up] < sh_keys[p]) break;
            heap_swap(up, p);
            p = up;
        end
    endfunction

    // Move down; prefer the right child unless the left one is strictly earlier.
    function automatic bit heap_sink(int start);
        int p;
        int l;
        int m;
        p = start;
        forever begin
            l = 2 * p;
            if (l > sh_count) break;
            m = l;
            if (l + 1 <= sh_count && !(sh_keys[l] < sh_keys[l+1])) m = l + 1;
            if (sh_keys[p] < sh_keys[m]) break;
            heap_swap(p, m);
            p = m;
        end
        return p > start;
    endfunction

    // Fill the hole at p with the last entry, then repair the heap around it.
    function automatic void heap_take(int p, bit may_rise);
        int last;
        logic [IW-1:0] gone;
        last = sh_count;
        gone = sh_ids[p];
        if (p != last) heap_swap(last, p);
        sh_pos[gone] = '0;
        sh_count = last - 1;
        if (p != last) begin
            if (!heap_sink(p) && may_rise) heap_rise(p);
        end
    endfunction

    function automatic t_result timer_queue_apply(t_cmd c, logic [IW-1:0] id,
                                                  logic [KW-1:0] key);
        t_result r;
        bit popped;
        r = '0;
        r.status = ST_OK;
        popped = 1'b0;
        case (c)
            CMD_INSERT: begin
                if (sh_count >= HEAP_DEPTH) begin
                    r.status = ST_FULL;
                end else if (sh_pos[id] != 0) begin
                    r.status = ST_PRESENT;
                end else begin
                    sh_count++;
                    sh_ids[sh_count] = id;
                    sh_keys[sh_count] = key;
                    sh_pos[id] = PW'(sh_count);
                    heap_rise(sh_count);
                end
            end
            CMD_POP: begin
                if (sh_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    popped = 1'b1;
                    r.id = sh_ids[1];
                    r.expire = sh_keys[1];
                    heap_take(1, 1'b0);
                end
            end
            CMD_DELETE: begin
                if (sh_count == 0) r.status = ST_EMPTY;
                else if (sh_pos[id] == 0) r.status = ST_NOTFOUND;
                else heap_take(sh_pos[id], 1'b1);
            end
            default: ;
        endcase
        if (!popped && sh_count > 0) begin
            r.id = sh_ids[1];
            r.expire = sh_keys[1];
        end
        r.count = PW'(sh_count);
        return r;
    endfunction

    // ---------------------------------------------------------------- sender
    // Drive one item at the falling edge and hold it until the block takes it.
    task automatic send_item(t_cmd c, logic [IW-1:0] id, logic [KW-1:0] key,
                             bit typed, t_result typed_res);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= c;
        in_if.timer_id <= id;
        in_if.expire_time <= key;
        do @(posedge i_clk); while (!in_if.ready);
        r = timer_queue_apply(c, id, key);
        results_due.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    task automatic send_predicted(t_cmd c, logic [IW-1:0] id, logic [KW-1:0] key);
        send_item(c, id, key, 1'b0, '0);
    endtask

    // Mostly well-formed traffic: deletes aim at held ids, ids and keys cluster
    // so that duplicates and equal expire times happen often.
    task automatic send_random();
        int op;
        logic [IW-1:0] id;
        logic [KW-1:0] key;
        op = $urandom_range(99);
        id = ($urandom_range(99) < 70) ? IW'($urandom_range(63)) : IW'($urandom);
        key = ($urandom_range(99) < 30) ? KW'($urandom_range(15)) : KW'($urandom);
        if (op < 45) begin
            send_predicted(CMD_INSERT, id, key);
        end else if (op < 70) begin
            send_predicted(CMD_POP, IW'($urandom), KW'($urandom));
        end else if (op < 95) begin
            if (sh_count > 0 && $urandom_range(99) < 70)
                id = sh_ids[$urandom_range(sh_count, 1)];
            send_predicted(CMD_DELETE, id, key);
        end else begin
            send_predicted(CMD_NOP, id, key);
        end
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                // Hold off long enough for the block to fill and stall its input.
                repeat (HOLD_CYCLES) begin
                    out_if.ready <= 1'b0;
                    @(negedge i_clk);
                end
                rx_hold_req = 1'b0;
            end
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result status=%0d id=%0d expire=%0d count=%0d",
                         $time, out_if.status, out_if.item_id, out_if.item_expire,
                         out_if.heap_count);
                n_errors++;
            end else begin
                want = results_due.pop_front();
                if (out_if.status !== want.status || out_if.item_id !== want.id ||
                    out_if.item_expire !== want.expire ||
                    out_if.heap_count !== want.count) begin
                    $display("%0t: mismatch expected status=%0d id=%0d expire=%0d count=%0d",
                             $time, want.status, want.id, want.expire, want.count);
                    $display("%0t:          actual   status=%0d id=%0d expire=%0d count=%0d",
                             $time, out_if.status, out_if.item_id, out_if.item_expire,
                             out_if.heap_count);
                    n_errors++;
                end
                if (want.status <= ST_PRESENT) status_seen[want.status]++;
            end
            n_checked++;
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- main flow
    initial begin
        t_row rows[$];
        int mode;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_NOP;
        in_if.timer_id = '0;
        in_if.expire_time = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        stall_cycles = 0;
        sh_count = 0;
        foreach (sh_pos[i]) sh_pos[i] = '0;

        // Directed rows: typed results follow from the empty heap and extremes.
        rows = '{
            '{CMD_POP,    10'd0,    31'd0,          1, '{ST_EMPTY,    10'd0,    31'd0, 11'd0}},
            '{CMD_DELETE, 10'd7,    31'd0,          1, '{ST_EMPTY,    10'd0,    31'd0, 11'd0}},
            '{CMD_NOP,    10'd1023, 31'h7fffffff,   1, '{ST_OK,       10'd0,    31'd0, 11'd0}},
            '{CMD_INSERT, 10'd1023, 31'h7fffffff,   1,
              '{ST_OK, 10'd1023, 31'h7fffffff, 11'd1}},
            '{CMD_INSERT, 10'd1023, 31'd5,          1,
              '{ST_PRESENT, 10'd1023, 31'h7fffffff, 11'd1}},
            '{CMD_INSERT, 10'd0,    31'd0,          1, '{ST_OK,       10'd0,    31'd0, 11'd2}},
            '{CMD_DELETE, 10'd5,    31'd0,          1, '{ST_NOTFOUND, 10'd0,    31'd0, 11'd2}},
            // an equal key climbs past its parent
            '{CMD_INSERT, 10'd5,    31'd0,          1, '{ST_OK,       10'd5,    31'd0, 11'd3}},
            '{CMD_POP,    10'd0,    31'd0,          1, '{ST_OK,       10'd5,    31'd0, 11'd2}},
            '{CMD_POP,    10'd0,    31'd0,          1, '{ST_OK,       10'd0,    31'd0, 11'd1}},
            '{CMD_DELETE, 10'd1023, 31'd0,          1, '{ST_OK,       10'd0,    31'd0, 11'd0}},
            '{CMD_INSERT, 10'd40,   31'd900,        0, '0},
            '{CMD_INSERT, 10'd41,   31'd300,        0, '0},
            '{CMD_INSERT, 10'd42,   31'd300,        0, '0},
            '{CMD_INSERT, 10'd43,   31'd100,        0, '0},
            '{CMD_INSERT, 10'd44,   31'd700,        0, '0},
            '{CMD_INSERT, 10'd45,   31'd50,         0, '0},
            // delete from the middle: the moved entry rises
            '{CMD_DELETE, 10'd44,   31'd0,          0, '0},
            // delete of the root: the moved entry sinks
            '{CMD_DELETE, 10'd45,   31'd0,          0, '0},
            // delete of the last position needs no repair
            '{CMD_DELETE, 10'd40,   31'd0,          0, '0},
            '{CMD_POP,    10'd0,    31'd0,          0, '0},
            '{CMD_NOP,    10'd0,    31'd0,          0, '0},
            '{CMD_POP,    10'd0,    31'd0,          0, '0},
            '{CMD_POP,    10'd0,    31'd0,          0, '0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].id, rows[i].key, rows[i].typed, rows[i].res);

        for (mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 16 : (mode == 1) ? 49 : 0;
            rx_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 16 : 0;
            if (mode == 2) begin
                rx_hold_req = 1'b1;
                // Fill to capacity, then push against the full heap.
                for (int id = 0; id < ID_SPACE; id++)
                    send_predicted(CMD_INSERT, IW'(id),
                                   ($urandom_range(3) == 0) ? KW'($urandom_range(7))
                                                            : KW'($urandom));
                repeat (4) send_predicted(CMD_INSERT, IW'($urandom), KW'($urandom));
                repeat (40) send_random();
                repeat (60) send_predicted(CMD_POP, '0, '0);
            end
            repeat (RANDOM_PER_MODE) send_random();
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("tb: %0d items sent, %0d results checked, heap filled to %0d", n_sent,
                 n_checked, HEAP_DEPTH);
        $display("tb: status counts ok=%0d empty=%0d full=%0d notfound=%0d present=%0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
                 status_seen[ST_NOTFOUND], status_seen[ST_PRESENT]);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/imh_pkg.sv
rtl/imh_if.sv
rtl/indexed_min_heap_timer_queue.sv
tb/sv/indexed_min_heap_timer_queue_tb.sv
